// ----- rtl/core/qmd_pkg.sv -----
// ----------------------------------------------------------------------------
// qmd_pkg
// Shared types, constants and helper functions of the max-log QAM soft
// demapper: payload structs, pipeline widths and the constellation levels.
// ----------------------------------------------------------------------------
`default_nettype none

package qmd_pkg;

  // Sizing of the datapath.
  localparam int MAX_BITS    = 8;
  localparam int IQ_WIDTH    = 16;
  localparam int LLR_WIDTH   = 16;
  localparam int NUM_LANES   = 8;
  localparam int LANE_W      = 3;
  localparam int MAX_HALF    = MAX_BITS / 2;
  localparam int MAX_LEVELS  = 1 << MAX_HALF;
  localparam int HALF_LEVELS = MAX_LEVELS / 2;

  // Level amplitudes reach at most 4710 in Q.12, which fits 14 signed bits.
  localparam int AMP_W     = 14;
  localparam int D_W       = ((IQ_WIDTH > AMP_W) ? IQ_WIDTH : AMP_W) + 1;
  localparam int SQ_W      = 2 * D_W - 1;
  localparam int DIFF_W    = SQ_W + 1;
  localparam int INV_W     = 16;
  localparam int PROD_W    = DIFF_W + INV_W + 1;
  localparam int LLR_SHIFT = 28;
  localparam int SH_W      = PROD_W - LLR_SHIFT;
  localparam int SAT_W     = ((SH_W > LLR_WIDTH) ? SH_W : LLR_WIDTH) + 1;

  localparam int ORD_W      = 2;
  localparam int HALF_W     = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_NOISE = 1'd1;

  // Half-width codes (bits per I or Q axis) of QPSK, 16-QAM and 64-QAM.
  localparam logic [HALF_W-1:0] HALF_QPSK   = 3'd1;
  localparam logic [HALF_W-1:0] HALF_QAM16  = 3'd2;
  localparam logic [HALF_W-1:0] HALF_QAM64  = 3'd3;

  // Register reset values.
  localparam logic [ORD_W-1:0] ORD_RESET = 2'd0;
  localparam logic [INV_W-1:0] INV_RESET = 16'd256;

  typedef logic signed [IQ_WIDTH-1:0]  iq_t;
  typedef logic signed [LLR_WIDTH-1:0] llr_t;

  typedef struct packed {
    iq_t sym_i;
    iq_t sym_q;
  } sym_req_t;

  typedef struct packed {
    llr_t             llr_0;
    llr_t             llr_1;
    llr_t             llr_2;
    llr_t             llr_3;
    llr_t             llr_4;
    llr_t             llr_5;
    llr_t             llr_6;
    llr_t             llr_7;
    logic [CNT_W-1:0] bit_count;
  } llr_rsp_t;

  typedef logic [SQ_W-1:0]          sq_t;
  typedef sq_t [MAX_LEVELS-1:0]     sq_vec_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef diff_t [MAX_HALF-1:0]     diff_half_t;
  typedef diff_t [NUM_LANES-1:0]    diff_lane_t;
  typedef llr_t [NUM_LANES-1:0]     llr_lane_t;

  // Load enables of the pipeline stages after the input register.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  // Bits per axis for a requested order, clamped to what MAX_BITS allows.
  function automatic logic [HALF_W-1:0] eff_half(input logic [ORD_W-1:0] ord);
    int o;
    o = int'(ord);
    for (int i = 0; i < 3; i++) begin
      if (o > 0 && 2 * (o + 1) > MAX_BITS) begin
        o = o - 1;
      end
    end
    return HALF_W'(o + 1);
  endfunction

  // Amplitude of binary level v: (L - 1 - 2v) * scale, in Q.12.
  function automatic logic signed [AMP_W-1:0] level_amp(input logic [HALF_W-1:0] half,
                                                        input int v);
    int scale;
    int lv;
    case (half)
      HALF_QPSK:  scale = 2896;
      HALF_QAM16: scale = 1295;
      HALF_QAM64: scale = 632;
      default:    scale = 314;
    endcase
    lv = 1 << half;
    return AMP_W'((lv - 1 - 2 * v) * scale);
  endfunction

  // Bit pos of the Gray code that labels binary level v.
  function automatic logic gray_bit(input int v, input int pos);
    int g;
    g = v ^ (v >> 1);
    return ((g >> pos) & 1) != 0;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qam_maxlog_llr_demapper_unit.sv -----
// ----------------------------------------------------------------------------
// qam_maxlog_llr_demapper_unit
// Max-log LLR soft demapper for Gray-coded QPSK, 16, 64 and 256-QAM.
// Stages: input register, squared distances, partial minima, bit differences, products, saturation.
// Throughput: one symbol per cycle, set by the six-stage pipeline, while out_stall_i does not hold it.
// The pipeline holds bubbles only where no request is in flight.
// Reset clears all stage valid bits and loads QPSK and 1.0 noise scale.
// ----------------------------------------------------------------------------
`default_nettype none

module qam_maxlog_llr_demapper_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire qmd_pkg::sym_req_t                in_req_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output qmd_pkg::llr_rsp_t                     out_rsp_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [qmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [qmd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int Stages = 6;

  logic [qmd_pkg::ORD_W-1:0]  mod_order_q;
  logic [qmd_pkg::INV_W-1:0]  inv_q;
  logic [qmd_pkg::HALF_W-1:0] half;

  logic [Stages-1:0] vld_d;
  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] rdy;
  logic [Stages-1:0] ld;
  qmd_pkg::stage_en_t en;

  qmd_pkg::iq_t sym_i_q;
  qmd_pkg::iq_t sym_q_q;

  qmd_pkg::sq_vec_t    sq_i;
  qmd_pkg::sq_vec_t    sq_q;
  qmd_pkg::diff_half_t diff_i;
  qmd_pkg::diff_half_t diff_q;
  qmd_pkg::diff_lane_t lane_diff;
  qmd_pkg::llr_lane_t  llr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_order_q <= qmd_pkg::ORD_RESET;
      inv_q       <= qmd_pkg::INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qmd_pkg::CFG_MOD_ORDER: mod_order_q <= cfg_wdata_i[qmd_pkg::ORD_W-1:0];
        qmd_pkg::CFG_INV_NOISE: inv_q       <= cfg_wdata_i[qmd_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  assign half = qmd_pkg::eff_half(mod_order_q);

  // A stage takes new data when it is empty or its successor moves on.
  always_comb begin
    rdy[Stages-1] = !vld_q[Stages-1] || !out_stall_i;
    for (int s = Stages - 2; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
    ld[0]    = in_valid_i && rdy[0];
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int s = 1; s < Stages; s++) begin
      ld[s]    = vld_q[s-1] && rdy[s];
      vld_d[s] = rdy[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en.s2 = ld[1];
  assign en.s3 = ld[2];
  assign en.s4 = ld[3];
  assign en.s5 = ld[4];
  assign en.s6 = ld[5];

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[Stages-1];

  // Input register.
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      sym_i_q <= in_req_i.sym_i;
      sym_q_q <= in_req_i.sym_q;
    end
  end

  // Squared distances per axis.
  qmd_sq_dist u_sq_i (
    .clk_i  (clk_i),
    .en_i   (en.s2),
    .y_i    (sym_i_q),
    .half_i (half),
    .sq_o   (sq_i)
  );

  qmd_sq_dist u_sq_q (
    .clk_i  (clk_i),
    .en_i   (en.s2),
    .y_i    (sym_q_q),
    .half_i (half),
    .sq_o   (sq_q)
  );

  // Per-bit minima per axis; the other axis cancels out of the difference.
  qmd_bit_min u_min_i (
    .clk_i     (clk_i),
    .en_part_i (en.s3),
    .en_diff_i (en.s4),
    .sq_i      (sq_i),
    .half_i    (half),
    .diff_o    (diff_i)
  );

  qmd_bit_min u_min_q (
    .clk_i     (clk_i),
    .en_part_i (en.s3),
    .en_diff_i (en.s4),
    .sq_i      (sq_q),
    .half_i    (half),
    .diff_o    (diff_q)
  );

  // I bits take the first lanes, Q bits follow; unused lanes are zero.
  always_comb begin
    lane_diff = '0;
    for (int j = 0; j < qmd_pkg::MAX_HALF; j++) begin
      if (j < int'(half)) begin
        lane_diff[j] = diff_i[j];
        lane_diff[qmd_pkg::LANE_W'(int'(half) + j)] = diff_q[j];
      end
    end
  end

  qmd_llr_scale u_scale (
    .clk_i    (clk_i),
    .en_mul_i (en.s5),
    .en_sat_i (en.s6),
    .diff_i   (lane_diff),
    .inv_i    (inv_q),
    .llr_o    (llr)
  );

  // Result response.
  assign out_rsp_o.llr_0     = llr[0];
  assign out_rsp_o.llr_1     = llr[1];
  assign out_rsp_o.llr_2     = llr[2];
  assign out_rsp_o.llr_3     = llr[3];
  assign out_rsp_o.llr_4     = llr[4];
  assign out_rsp_o.llr_5     = llr[5];
  assign out_rsp_o.llr_6     = llr[6];
  assign out_rsp_o.llr_7     = llr[7];
  assign out_rsp_o.bit_count = {half, 1'b0};

endmodule

`default_nettype wire

// ----- rtl/core/qmd_sq_dist.sv -----
// ----------------------------------------------------------------------------
// qmd_sq_dist
// Squared distance from one received axis sample to every level of that
// axis, one registered multiplier per level.
// ----------------------------------------------------------------------------
`default_nettype none

module qmd_sq_dist (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire qmd_pkg::iq_t                  y_i,
  input  wire logic [qmd_pkg::HALF_W-1:0]    half_i,
  output qmd_pkg::sq_vec_t                   sq_o
);

  qmd_pkg::sq_vec_t sq_d;
  qmd_pkg::sq_vec_t sq_q;
  logic signed [qmd_pkg::D_W-1:0] y_ext;

  assign y_ext = qmd_pkg::D_W'(y_i);

  // One subtract and square per level; levels beyond the order are ignored later.
  for (genvar v = 0; v < qmd_pkg::MAX_LEVELS; v++) begin : g_level
    logic signed [qmd_pkg::D_W-1:0]   delta;
    logic signed [2*qmd_pkg::D_W-1:0] delta_sq;

    assign delta    = y_ext - qmd_pkg::D_W'(qmd_pkg::level_amp(half_i, v));
    assign delta_sq = delta * delta;
    assign sq_d[v]  = delta_sq[qmd_pkg::SQ_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ----- rtl/core/qmd_bit_min.sv -----
// ----------------------------------------------------------------------------
// qmd_bit_min
// Per-bit minimum squared distances of one axis, split into two registered
// halves, then the set-minus-clear difference for each bit of the axis.
// ----------------------------------------------------------------------------
`default_nettype none

module qmd_bit_min (
  input  wire logic                        clk_i,
  input  wire logic                        en_part_i,
  input  wire logic                        en_diff_i,
  input  wire qmd_pkg::sq_vec_t            sq_i,
  input  wire logic [qmd_pkg::HALF_W-1:0]  half_i,
  output qmd_pkg::diff_half_t              diff_o
);

  // Index order: bit of the axis, bit value, half of the level range.
  qmd_pkg::sq_t part_d [qmd_pkg::MAX_HALF][2][2];
  qmd_pkg::sq_t part_q [qmd_pkg::MAX_HALF][2][2];
  qmd_pkg::diff_half_t diff_d;
  qmd_pkg::diff_half_t diff_q;

  // Partial minima over each half of the levels. An empty set keeps the
  // all-ones value, which no real squared distance reaches.
  always_comb begin
    int h;
    int lv;
    int v;
    h  = int'(half_i);
    lv = 1 << h;
    for (int j = 0; j < qmd_pkg::MAX_HALF; j++) begin
      for (int b = 0; b < 2; b++) begin
        for (int p = 0; p < 2; p++) begin
          part_d[j][b][p] = '1;
          for (int i = 0; i < qmd_pkg::HALF_LEVELS; i++) begin
            v = p * qmd_pkg::HALF_LEVELS + i;
            if (j < h && v < lv &&
                qmd_pkg::gray_bit(v, h - 1 - j) == (b != 0) &&
                sq_i[v] < part_d[j][b][p]) begin
              part_d[j][b][p] = sq_i[v];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_part_i) begin
      part_q <= part_d;
    end
  end

  // Merge the halves and take min(bit set) - min(bit clear).
  always_comb begin
    qmd_pkg::sq_t min_set;
    qmd_pkg::sq_t min_clr;
    for (int j = 0; j < qmd_pkg::MAX_HALF; j++) begin
      min_set = (part_q[j][1][1] < part_q[j][1][0]) ? part_q[j][1][1] : part_q[j][1][0];
      min_clr = (part_q[j][0][1] < part_q[j][0][0]) ? part_q[j][0][1] : part_q[j][0][0];
      diff_d[j] = $signed({1'b0, min_set}) - $signed({1'b0, min_clr});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_diff_i) begin
      diff_q <= diff_d;
    end
  end

  assign diff_o = diff_q;

endmodule

`default_nettype wire

// ----- rtl/core/qmd_llr_scale.sv -----
// ----------------------------------------------------------------------------
// qmd_llr_scale
// Scales each lane's distance difference by 1/(2 sigma^2), then takes the
// floor shift to Q11.4 and saturates to the LLR width.
// ----------------------------------------------------------------------------
`default_nettype none

module qmd_llr_scale (
  input  wire logic                        clk_i,
  input  wire logic                        en_mul_i,
  input  wire logic                        en_sat_i,
  input  wire qmd_pkg::diff_lane_t         diff_i,
  input  wire logic [qmd_pkg::INV_W-1:0]   inv_i,
  output qmd_pkg::llr_lane_t               llr_o
);

  localparam logic signed [qmd_pkg::SAT_W-1:0] LlrMax =
    qmd_pkg::SAT_W'((1 << (qmd_pkg::LLR_WIDTH - 1)) - 1);
  localparam logic signed [qmd_pkg::SAT_W-1:0] LlrMin =
    qmd_pkg::SAT_W'(-(1 << (qmd_pkg::LLR_WIDTH - 1)));

  logic signed [qmd_pkg::PROD_W-1:0] prod_d [qmd_pkg::NUM_LANES];
  logic signed [qmd_pkg::PROD_W-1:0] prod_q [qmd_pkg::NUM_LANES];
  qmd_pkg::llr_lane_t llr_d;
  qmd_pkg::llr_lane_t llr_q;
  logic signed [qmd_pkg::INV_W:0] inv_s;

  assign inv_s = $signed({1'b0, inv_i});

  // One multiplier per lane.
  always_comb begin
    for (int k = 0; k < qmd_pkg::NUM_LANES; k++) begin
      prod_d[k] = $signed(diff_i[k]) * inv_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      prod_q <= prod_d;
    end
  end

  // Dropping the low bits of a signed value is a floor division.
  always_comb begin
    logic signed [qmd_pkg::SH_W-1:0]  shifted;
    logic signed [qmd_pkg::SAT_W-1:0] wide;
    for (int k = 0; k < qmd_pkg::NUM_LANES; k++) begin
      shifted = prod_q[k][qmd_pkg::PROD_W-1:qmd_pkg::LLR_SHIFT];
      wide    = qmd_pkg::SAT_W'(shifted);
      if (wide > LlrMax) begin
        llr_d[k] = LlrMax[qmd_pkg::LLR_WIDTH-1:0];
      end else if (wide < LlrMin) begin
        llr_d[k] = LlrMin[qmd_pkg::LLR_WIDTH-1:0];
      end else begin
        llr_d[k] = wide[qmd_pkg::LLR_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_sat_i) begin
      llr_q <= llr_d;
    end
  end

  assign llr_o = llr_q;

endmodule

`default_nettype wire

// ----- tb/tb_qam_maxlog_llr_demapper_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_qam_maxlog_llr_demapper_unit
// Self-checking regression of the max-log QAM soft demapper. Every accepted
// symbol request is scored by a behavioral LLR predictor that searches the
// whole constellation. Each result from the block is compared field by field
// with the oldest prediction. Traffic runs with no idling, a sparse sender,
// a heavily stalling receiver and a mix of both, across all four orders.
// ----------------------------------------------------------------------------

module tb_qam_maxlog_llr_demapper_unit;
  import qmd_pkg::*;

  // Constellation order codes of the mod_order register.
  localparam logic [ORD_W-1:0] ORD_QPSK   = 2'd0;
  localparam logic [ORD_W-1:0] ORD_QAM16  = 2'd1;
  localparam logic [ORD_W-1:0] ORD_QAM64  = 2'd2;
  localparam logic [ORD_W-1:0] ORD_QAM256 = 2'd3;

  localparam int ITEMS_PER_SETTING = 56;
  localparam int SETTLE_CYCLES     = 12;
  localparam int CYCLE_LIMIT       = 400000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  sym_req_t              in_req;
  logic                  out_valid;
  logic                  out_stall;
  llr_rsp_t              out_rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the configuration registers.
  logic [ORD_W-1:0] cur_order;
  logic [INV_W-1:0] cur_inv;

  llr_rsp_t pending_llrs[$];
  int       sender_idle_pct;
  int       recv_stall_pct;
  int       symbols_sent;
  int       results_checked;
  int       error_count;
  int       cycle_count;

  qam_maxlog_llr_demapper_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Free-running 2 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Half the level spacing of each constellation in Q.12.
  function automatic int qam_scale(input logic [ORD_W-1:0] ord);
    case (ord)
      ORD_QPSK:  return 2896;
      ORD_QAM16: return 1295;
      ORD_QAM64: return 632;
      default:   return 314;
    endcase
  endfunction

  // Exhaustive max-log LLR computation over every constellation point.
  function automatic llr_rsp_t predict_llrs(input iq_t si, input iq_t sq);
    int       ord;
    int       nbits;
    int       half;
    int       levels;
    int       gi;
    int       gq;
    int       v;
    int       t;
    longint   scale;
    longint   yi;
    longint   yq;
    longint   di;
    longint   dq;
    longint   d2;
    longint   prod;
    longint   sat_hi;
    longint   sat_lo;
    longint   amp[16];
    longint   min_set[NUM_LANES];
    longint   min_clr[NUM_LANES];
    bit       seen_set[NUM_LANES];
    bit       seen_clr[NUM_LANES];
    llr_t     lane[NUM_LANES];
    llr_rsp_t r;

    ord = int'(cur_order);
    while (ord > 0 && 2 * (ord + 1) > MAX_BITS) ord--;
    nbits  = 2 * (ord + 1);
    half   = nbits / 2;
    levels = 1 << half;
    scale  = longint'(qam_scale(ORD_W'(ord)));
    yi     = longint'(si);
    yq     = longint'(sq);
    sat_hi = (longint'(1) << (LLR_WIDTH - 1)) - 1;
    sat_lo = -(longint'(1) << (LLR_WIDTH - 1));

    // Amplitude of each Gray label: decode to binary, then map to a level.
    for (int g = 0; g < levels; g++) begin
      v = g;
      t = g >> 1;
      while (t != 0) begin
        v = v ^ t;
        t = t >> 1;
      end
      amp[g] = (longint'(levels) - 1 - 2 * longint'(v)) * scale;
    end

    for (int k = 0; k < NUM_LANES; k++) begin
      min_set[k]  = 0;
      min_clr[k]  = 0;
      seen_set[k] = 1'b0;
      seen_clr[k] = 1'b0;
      lane[k]     = '0;
    end

    // Track the nearest point on each side of every bit.
    for (int s = 0; s < (1 << nbits); s++) begin
      gi = (s >> half) & (levels - 1);
      gq = s & (levels - 1);
      di = yi - amp[gi];
      dq = yq - amp[gq];
      d2 = di * di + dq * dq;
      for (int k = 0; k < nbits; k++) begin
        if (((s >> (nbits - 1 - k)) & 1) != 0) begin
          if (!seen_set[k] || d2 < min_set[k]) begin
            min_set[k]  = d2;
            seen_set[k] = 1'b1;
          end
        end else begin
          if (!seen_clr[k] || d2 < min_clr[k]) begin
            min_clr[k]  = d2;
            seen_clr[k] = 1'b1;
          end
        end
      end
    end

    // Scale by the noise term, floor to Q11.4 and saturate.
    for (int k = 0; k < nbits; k++) begin
      prod = longint'(cur_inv) * (min_set[k] - min_clr[k]);
      prod = prod >>> LLR_SHIFT;
      if (prod > sat_hi) prod = sat_hi;
      if (prod < sat_lo) prod = sat_lo;
      lane[k] = llr_t'(prod);
    end

    r.llr_0     = lane[0];
    r.llr_1     = lane[1];
    r.llr_2     = lane[2];
    r.llr_3     = lane[3];
    r.llr_4     = lane[4];
    r.llr_5     = lane[5];
    r.llr_6     = lane[6];
    r.llr_7     = lane[7];
    r.bit_count = CNT_W'(nbits);
    return r;
  endfunction

  // One field of a result; index NUM_LANES selects bit_count.
  function automatic logic signed [LLR_WIDTH-1:0] rsp_field(input llr_rsp_t r, input int k);
    case (k)
      0:       return r.llr_0;
      1:       return r.llr_1;
      2:       return r.llr_2;
      3:       return r.llr_3;
      4:       return r.llr_4;
      5:       return r.llr_5;
      6:       return r.llr_6;
      7:       return r.llr_7;
      default: return LLR_WIDTH'(r.bit_count);
    endcase
  endfunction

  // Mostly noisy symbols near a random point, with some wide and raw values.
  function automatic iq_t random_component(input logic [ORD_W-1:0] ord);
    int levels;
    int pick;
    int val;
    levels = 2 << ord;
    pick   = $urandom_range(99);
    if (pick < 60) begin
      val = (levels - 1 - 2 * int'($urandom_range(levels - 1))) * qam_scale(ord)
            + int'($urandom_range(1600)) - 800;
    end else if (pick < 80) begin
      val = int'($urandom_range(12000)) - 6000;
    end else begin
      val = int'($urandom);
    end
    return iq_t'(val);
  endfunction

  // Receiver stall pattern, updated on the falling edge.
  always @(negedge clk_i) begin
    out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    llr_rsp_t exp_rsp;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_llrs.size() == 0) begin
        $display("%0t: result with no pending request, got %h", $time, out_rsp);
        error_count++;
      end else begin
        exp_rsp = pending_llrs.pop_front();
        results_checked++;
        for (int k = 0; k <= NUM_LANES; k++) begin
          if (rsp_field(out_rsp, k) !== rsp_field(exp_rsp, k)) begin
            error_count++;
            if (k < NUM_LANES) begin
              $display("%0t: llr_%0d mismatch, expected %0d, actual %0d", $time, k,
                       rsp_field(exp_rsp, k), rsp_field(out_rsp, k));
            end else begin
              $display("%0t: bit_count mismatch, expected %0d, actual %0d", $time,
                       exp_rsp.bit_count, out_rsp.bit_count);
            end
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results pending", $time, pending_llrs.size());
    $display("qam_maxlog_llr_demapper_unit regression: fail");
    $finish;
  end

  // Send one symbol request; called and returning on a falling edge.
  task automatic send_symbol(input iq_t si, input iq_t sq);
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    in_req.sym_i <= si;
    in_req.sym_q <= sq;
    do @(posedge clk_i); while (in_stall);
    pending_llrs = {pending_llrs, predict_llrs(si, sq)};
    symbols_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and wait until the pipeline has emptied.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_llrs.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write both registers; only called while the block is idle.
  task automatic set_config(input logic [ORD_W-1:0] ord, input logic [INV_W-1:0] inv);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MOD_ORDER;
    cfg_wdata <= {(CFG_DATA_W - ORD_W)'($urandom), ord};
    @(posedge clk_i);
    cur_order = ord;
    @(negedge clk_i);
    cfg_idx   <= CFG_INV_NOISE;
    cfg_wdata <= inv;
    @(posedge clk_i);
    cur_inv = inv;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // The reset values alone must give QPSK at unit noise scale.
  task automatic test_reset_defaults();
    send_symbol(iq_t'(2896), iq_t'(-2896));
    send_symbol(iq_t'(100), iq_t'(-4000));
    send_symbol(iq_t'(-32768), iq_t'(32767));
    drain_pipeline();
  endtask

  // Corners, on-point symbols and distance ties at maximum noise scale.
  task automatic test_constellation_corners();
    int outer;
    for (int o = 0; o < 4; o++) begin
      set_config(ORD_W'(o), 16'hFFFF);
      outer = ((2 << o) - 1) * qam_scale(ORD_W'(o));
      send_symbol(iq_t'(32767), iq_t'(32767));
      send_symbol(iq_t'(-32768), iq_t'(-32768));
      send_symbol(iq_t'(32767), iq_t'(-32768));
      send_symbol(iq_t'(0), iq_t'(0));
      send_symbol(iq_t'(outer), iq_t'(-outer));
      drain_pipeline();
    end
  endtask

  // A zero inverse noise term forces every LLR to zero.
  task automatic test_zero_noise();
    set_config(ORD_QAM256, 16'h0000);
    send_symbol(iq_t'(-32768), iq_t'(12345));
    send_symbol(iq_t'(4710), iq_t'(-1))  ;
    drain_pipeline();
  endtask

  // Random traffic over all orders under one idling mix.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic [INV_W-1:0] inv;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int o = 0; o < 4; o++) begin
      case ($urandom_range(4))
        0:       inv = 16'hFFFF;
        1:       inv = 16'h0001;
        2:       inv = 16'h0100;
        default: inv = INV_W'($urandom);
      endcase
      set_config(ORD_W'(o), inv);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        send_symbol(random_component(ORD_W'(o)), random_component(ORD_W'(o)));
      end
      drain_pipeline();
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    in_req          = '0;
    out_stall       = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_MOD_ORDER;
    cfg_wdata       = '0;
    cur_order       = ORD_RESET;
    cur_inv         = INV_RESET;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    symbols_sent    = 0;
    results_checked = 0;
    error_count     = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_constellation_corners();
    test_zero_noise();
    test_random_traffic(0, 0);
    test_random_traffic(87, 0);
    test_random_traffic(0, 87);
    test_random_traffic(23, 23);

    drain_pipeline();
    $display("Covered %0d symbols over QPSK, 16, 64 and 256-QAM; %0d results checked.",
             symbols_sent, results_checked);
    $display("Noise scales ran from 0 to 65535 under four sender and receiver idle mixes.");
    if (error_count == 0) begin
      $display("qam_maxlog_llr_demapper_unit regression: pass");
    end else begin
      $display("qam_maxlog_llr_demapper_unit regression: fail");
    end
    $finish;
  end

endmodule
